@@ hdl/ultrasonic_parking_ranger_macros.svh @@
// Assertion macros shared by the ultrasonic parking ranger checker.
// Standalone header; no dependencies.
`ifndef ULTRASONIC_PARKING_RANGER_MACROS_SVH
`define ULTRASONIC_PARKING_RANGER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upr check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upr check failed");

`endif

@@ hdl/upr_pkg.sv @@
// Shared types, widths, codes and reset values of the ultrasonic parking ranger.
// No dependencies; every other RTL file imports this package.
package upr_pkg;

  localparam int COUNT_W    = 24;
  localparam int TIMER_W    = 20;
  localparam int DIST_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = COUNT_W + SCALE_W;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int LAMP_W     = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CM_PER_TICK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_CM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_TICKS    = 3'd4;

  // Register reset values
  localparam logic [TIMER_W-1:0] RST_TRIGGER_TICKS = 20'd10000;
  localparam logic [SCALE_W-1:0] RST_CM_PER_TICK   = 16'd1124;
  localparam logic [DIST_W-1:0]  RST_NEAR_CM       = 16'd10;
  localparam logic [DIST_W-1:0]  RST_FAR_CM        = 16'd60;
  localparam logic [TIMER_W-1:0] RST_BUZZ_TICKS    = 20'd300000;

  // One-hot lamp codes, with all zeros for off
  localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_RED    = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'b100;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_COUNT = 3'd3,
    PH_BUZZ  = 3'd4
  } phase_t;

  // One sampled tick of the sensor pins
  typedef struct packed {
    logic motion;
    logic echo;
  } tick_t;

  // Live configuration
  typedef struct packed {
    logic [TIMER_W-1:0] trigger_ticks;
    logic [SCALE_W-1:0] cm_per_tick;
    logic [DIST_W-1:0]  near_cm;
    logic [DIST_W-1:0]  far_cm;
    logic [TIMER_W-1:0] buzz_ticks;
  } cfg_t;

endpackage

@@ hdl/upr_cfg_regs.sv @@
// Configuration register file of the ultrasonic parking ranger.
// Depends on upr_pkg for the register indexes, widths and reset values.
module upr_cfg_regs import upr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Always take a write beat
  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  // Decode the index; drop writes beyond the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= RST_TRIGGER_TICKS;
      cfg_r.cm_per_tick   <= RST_CM_PER_TICK;
      cfg_r.near_cm       <= RST_NEAR_CM;
      cfg_r.far_cm        <= RST_FAR_CM;
      cfg_r.buzz_ticks    <= RST_BUZZ_TICKS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS: cfg_r.trigger_ticks <= cfg_data[TIMER_W-1:0];
        CFG_CM_PER_TICK:   cfg_r.cm_per_tick   <= cfg_data[SCALE_W-1:0];
        CFG_NEAR_CM:       cfg_r.near_cm       <= cfg_data[DIST_W-1:0];
        CFG_FAR_CM:        cfg_r.far_cm        <= cfg_data[DIST_W-1:0];
        CFG_BUZZ_TICKS:    cfg_r.buzz_ticks    <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/upr_in_reg.sv @@
// Input register of the ultrasonic parking ranger: holds one sampled tick.
// Depends on upr_pkg for tick_t.
module upr_in_reg import upr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_motion,
  input  logic  in_echo,
  output logic  s1_valid,
  output tick_t s1_tick,
  input  logic  s1_take
);

  logic  valid_r;
  tick_t tick_r;

  // Accept a new beat when empty or when the held one moves on this cycle
  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_tick  = tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_r.motion <= in_motion;
      tick_r.echo   <= in_echo;
    end
  end

endmodule

@@ hdl/upr_core.sv @@
// Ranging sequencer and result register of the ultrasonic parking ranger.
// Depends on upr_pkg for phase_t, tick_t, cfg_t, lamp codes and widths.
module upr_core import upr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  tick_t             s1_tick,
  output logic              s1_take,
  input  cfg_t              cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_trigger,
  output logic              out_led_red,
  output logic              out_led_yellow,
  output logic              out_led_green,
  output logic              out_buzzer,
  output logic [DIST_W-1:0] out_distance_cm,
  output logic              out_measure_done,
  output logic              out_busy_res
);

  phase_t              phase_r,  phase_nxt;
  logic [TIMER_W-1:0]  timer_r,  timer_nxt;
  logic [COUNT_W-1:0]  count_r,  count_nxt;
  logic [LAMP_W-1:0]   lamp_r,   lamp_nxt;
  logic [DIST_W-1:0]   dist_r,   dist_nxt;
  logic                done_r,   done_nxt;
  logic                valid_r;

  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   dist_sat;
  logic                is_near;
  logic                is_mid;

  // Advance one tick when the result register is free or being drained
  assign s1_take = s1_valid && (!valid_r || out_ready);

  // Scale the echo width to centimetres and saturate
  assign prod     = PROD_W'(count_r) * PROD_W'(cfg.cm_per_tick);
  assign dist_sat = (|prod[PROD_W-1:SCALE_W+DIST_W]) ? {DIST_W{1'b1}}
                                                      : prod[SCALE_W+DIST_W-1:SCALE_W];
  assign is_near  = dist_sat < cfg.near_cm;
  assign is_mid   = dist_sat < cfg.far_cm;

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    count_nxt = count_r;
    lamp_nxt  = lamp_r;
    dist_nxt  = dist_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_TRIG: begin
        if (timer_r <= TIMER_W'(1)) begin
          phase_nxt = PH_WAIT;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      PH_WAIT: begin
        if (s1_tick.echo) begin
          phase_nxt = PH_COUNT;
          count_nxt = COUNT_W'(1);
        end
      end
      PH_COUNT: begin
        if (s1_tick.echo) begin
          if (count_r != {COUNT_W{1'b1}}) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end else begin
          dist_nxt = dist_sat;
          done_nxt = 1'b1;
          if (is_near) begin
            lamp_nxt = LAMP_RED;
          end else if (is_mid) begin
            lamp_nxt = LAMP_YELLOW;
          end else begin
            lamp_nxt = LAMP_GREEN;
          end
          if (is_near && (cfg.buzz_ticks != '0)) begin
            phase_nxt = PH_BUZZ;
            timer_nxt = cfg.buzz_ticks;
          end else begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
          end
        end
      end
      PH_BUZZ: begin
        if (timer_r <= TIMER_W'(1)) begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (s1_tick.motion) begin
          phase_nxt = PH_TRIG;
          timer_nxt = (cfg.trigger_ticks == '0) ? TIMER_W'(1) : cfg.trigger_ticks;
          count_nxt = '0;
        end
      end
    endcase
  end

  // State doubles as the result register: it only moves on an advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      count_r <= '0;
      lamp_r  <= LAMP_OFF;
      dist_r  <= '0;
      done_r  <= 1'b0;
    end else if (s1_take) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
      lamp_r  <= lamp_nxt;
      dist_r  <= dist_nxt;
      done_r  <= done_nxt;
    end
  end

  // Result beat valid: set on advance, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid        = valid_r;
  assign out_trigger      = (phase_r == PH_TRIG);
  assign out_led_red      = |(lamp_r & LAMP_RED);
  assign out_led_yellow   = |(lamp_r & LAMP_YELLOW);
  assign out_led_green    = |(lamp_r & LAMP_GREEN);
  assign out_buzzer       = (phase_r == PH_BUZZ);
  assign out_distance_cm  = dist_r;
  assign out_measure_done = done_r;
  assign out_busy_res     = (phase_r != PH_IDLE);

endmodule

@@ hdl/ultrasonic_parking_ranger.sv @@
// Top level of the ultrasonic parking ranger: input register, sequencer, config.
// Depends on upr_pkg, upr_in_reg, upr_core and upr_cfg_regs.
//
//   channel  | handshake              | beat contents
//   ---------+------------------------+---------------------------------------------
//   in_      | in_valid / in_ready    | motion, echo (one sampled tick)
//   out_     | out_valid / out_ready  | trigger, three LEDs, buzzer, distance_cm,
//            |                        | measure_done, busy_res
//   cfg_     | cfg_valid / cfg_ready  | cfg_index (3 bit), cfg_data (20 bit)
//
// One tick per clock sustained while out_ready stays high: an input beat lands in
// the input register, then updates the sequencer state (the result register) once
// the out channel is free or draining; out_valid is set on that advance. The
// distance multiply (24 x 16) and the threshold compares sit in that single step.
// A stalled out channel holds the result and the input register; in_ready
// drops only when both are full. cfg_ready is always high.
// Reset (rst_n low, synchronous) sets idle, LEDs off, distance zero.
module ultrasonic_parking_ranger import upr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_motion,
  input  logic                  in_echo,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger,
  output logic                  out_led_red,
  output logic                  out_led_yellow,
  output logic                  out_led_green,
  output logic                  out_buzzer,
  output logic [DIST_W-1:0]     out_distance_cm,
  output logic                  out_measure_done,
  output logic                  out_busy_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  s1_valid;
  tick_t s1_tick;
  logic  s1_take;
  cfg_t  cfg;

  upr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  upr_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_motion (in_motion),
    .in_echo   (in_echo),
    .s1_valid  (s1_valid),
    .s1_tick   (s1_tick),
    .s1_take   (s1_take)
  );

  upr_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_tick          (s1_tick),
    .s1_take          (s1_take),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger      (out_trigger),
    .out_led_red      (out_led_red),
    .out_led_yellow   (out_led_yellow),
    .out_led_green    (out_led_green),
    .out_buzzer       (out_buzzer),
    .out_distance_cm  (out_distance_cm),
    .out_measure_done (out_measure_done),
    .out_busy_res     (out_busy_res)
  );

endmodule

@@ hdl/upr_checker.sv @@
// Port-level checks of the ultrasonic parking ranger, bound to the top level.
// Depends on upr_pkg and ultrasonic_parking_ranger_macros.svh.
`include "ultrasonic_parking_ranger_macros.svh"

module upr_checker import upr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_trigger,
  input logic              out_led_red,
  input logic              out_led_yellow,
  input logic              out_led_green,
  input logic              out_buzzer,
  input logic [DIST_W-1:0] out_distance_cm,
  input logic              out_measure_done,
  input logic              out_busy_res
);

  // A stalled result beat stays offered with the same distance
  `UPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `UPR_ASSERT_NEXT(a_dist_hold, clk, rst_n, out_valid && !out_ready, $stable(out_distance_cm))

  // At most one lamp lit
  `UPR_ASSERT_NOW(a_one_lamp, clk, rst_n, out_valid,
                  $countones({out_led_red, out_led_yellow, out_led_green}) <= 1)

  // Trigger or buzzer only while busy, and never both
  `UPR_ASSERT_NOW(a_busy, clk, rst_n, out_valid && (out_trigger || out_buzzer),
                  out_busy_res && !(out_trigger && out_buzzer))

  // A finished measurement lights a lamp; buzzer only with red
  `UPR_ASSERT_NOW(a_done_lamp, clk, rst_n, out_valid && out_measure_done,
                  (out_led_red || out_led_yellow || out_led_green) && !out_trigger
                  && (!out_buzzer || out_led_red))

endmodule

bind ultrasonic_parking_ranger upr_checker u_upr_checker (.*);

@@ tb/tb.sv @@
// Self-checking bench for ultrasonic_parking_ranger: a directed table, then random
// measurement sequences, each beat scored against a cycle-true software ranger.
// Depends on upr_pkg and the ultrasonic_parking_ranger RTL.
module tb;
  import upr_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 80;
  localparam int LONG_ECHO     = 40;
  localparam int PAD_W         = CFG_DATA_W - DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = 3'd7;

  typedef struct packed {
    logic              trigger;
    logic              led_red;
    logic              led_yellow;
    logic              led_green;
    logic              buzzer;
    logic [DIST_W-1:0] distance_cm;
    logic              measure_done;
    logic              busy;
  } ranger_beat_t;

  typedef struct packed {
    logic         motion;
    logic         echo;
    logic         typed;
    ranger_beat_t want;
  } tick_row_t;

  // Directed walk, run with trigger 2, scale 65535 (distance = count - 1), near 3,
  // far 4, buzz 2: red with buzz, yellow, green, motion while busy, echo in trigger.
  localparam int DIRECTED_ROWS = 26;
  localparam tick_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1, 1'b1}},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd3, 1'b1, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd4, 1'b1, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_motion = 1'b0;
  logic                  in_echo   = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_trigger;
  logic                  out_led_red;
  logic                  out_led_yellow;
  logic                  out_led_green;
  logic                  out_buzzer;
  logic [DIST_W-1:0]     out_distance_cm;
  logic                  out_measure_done;
  logic                  out_busy_res;
  logic                  cfg_ready;

  // Software ranger state and its copy of the registers
  phase_t             rg_phase;
  logic [TIMER_W-1:0] rg_timer;
  logic [COUNT_W-1:0] rg_count;
  logic [LAMP_W-1:0]  rg_lamp;
  logic [DIST_W-1:0]  rg_dist;
  cfg_t               live_cfg;

  ranger_beat_t due_beats[$];
  int  mismatch_count = 0;
  int  beat_index     = 0;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  int  echo_mean      = 4;
  bit  in_idle_on     = 1'b1;
  bit  stall_on       = 1'b1;

  ultrasonic_parking_ranger u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_motion        (in_motion),
    .in_echo          (in_echo),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger      (out_trigger),
    .out_led_red      (out_led_red),
    .out_led_yellow   (out_led_yellow),
    .out_led_green    (out_led_green),
    .out_buzzer       (out_buzzer),
    .out_distance_cm  (out_distance_cm),
    .out_measure_done (out_measure_done),
    .out_busy_res     (out_busy_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the software ranger by one tick and return the beat it shows
  function automatic ranger_beat_t step_ranger(input logic motion, input logic echo);
    ranger_beat_t       beat;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  scaled;
    logic [DIST_W-1:0]  dist_now;
    logic               fell;
    fell = 1'b0;
    case (rg_phase)
      PH_TRIG: begin
        if (rg_timer <= 1) begin
          rg_phase = PH_WAIT;
          rg_timer = '0;
        end else begin
          rg_timer = rg_timer - 1'b1;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          rg_phase = PH_COUNT;
          rg_count = COUNT_W'(1);
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (rg_count != COUNT_MAX) rg_count = rg_count + 1'b1;
        end else begin
          product  = PROD_W'(rg_count) * PROD_W'(live_cfg.cm_per_tick);
          scaled   = product >> SCALE_W;
          dist_now = (scaled > PROD_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
          rg_dist  = dist_now;
          fell     = 1'b1;
          if (dist_now < live_cfg.near_cm)     rg_lamp = LAMP_RED;
          else if (dist_now < live_cfg.far_cm) rg_lamp = LAMP_YELLOW;
          else                                 rg_lamp = LAMP_GREEN;
          // Near object with a nonzero hold time sounds the buzzer
          if (dist_now < live_cfg.near_cm && live_cfg.buzz_ticks != '0) begin
            rg_phase = PH_BUZZ;
            rg_timer = live_cfg.buzz_ticks;
          end else begin
            rg_phase = PH_IDLE;
            rg_timer = '0;
          end
        end
      end
      PH_BUZZ: begin
        if (rg_timer <= 1) begin
          rg_phase = PH_IDLE;
          rg_timer = '0;
        end else begin
          rg_timer = rg_timer - 1'b1;
        end
      end
      default: begin
        rg_phase = PH_IDLE;
        if (motion) begin
          rg_phase = PH_TRIG;
          rg_timer = (live_cfg.trigger_ticks == '0) ? TIMER_W'(1) : live_cfg.trigger_ticks;
          rg_count = '0;
        end
      end
    endcase
    beat.trigger      = (rg_phase == PH_TRIG);
    beat.led_red      = (rg_lamp & LAMP_RED) != '0;
    beat.led_yellow   = (rg_lamp & LAMP_YELLOW) != '0;
    beat.led_green    = (rg_lamp & LAMP_GREEN) != '0;
    beat.buzzer       = (rg_phase == PH_BUZZ);
    beat.distance_cm  = rg_dist;
    beat.measure_done = fell;
    beat.busy         = (rg_phase != PH_IDLE);
    return beat;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: expected %0d got %0d",
                                beat_index, name, want, got));
  endtask

  // Offer one tick, after an optional gap, and log the beat it should produce
  task automatic push_tick(input logic motion, input logic echo, input logic typed,
                           input ranger_beat_t want);
    int           gap;
    ranger_beat_t predicted;
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_motion <= motion;
    in_echo   <= echo;
    predicted = step_ranger(motion, echo);
    due_beats.push_back(typed ? want : predicted);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every logged beat has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TRIGGER_TICKS: live_cfg.trigger_ticks = data[TIMER_W-1:0];
      CFG_CM_PER_TICK:   live_cfg.cm_per_tick   = data[SCALE_W-1:0];
      CFG_NEAR_CM:       live_cfg.near_cm       = data[DIST_W-1:0];
      CFG_FAR_CM:        live_cfg.far_cm        = data[DIST_W-1:0];
      CFG_BUZZ_TICKS:    live_cfg.buzz_ticks    = data[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, then load all registers; narrow ones get junk in the unused top bits
  task automatic configure(input logic [TIMER_W-1:0] trig, input logic [SCALE_W-1:0] scale,
                           input logic [DIST_W-1:0] near, input logic [DIST_W-1:0] far,
                           input logic [TIMER_W-1:0] buzz);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE));
    settle();
    write_reg(spare, CFG_DATA_W'($urandom));
    write_reg(CFG_TRIGGER_TICKS, trig);
    write_reg(CFG_CM_PER_TICK, {PAD_W'($urandom), scale});
    write_reg(CFG_NEAR_CM, {PAD_W'($urandom), near});
    write_reg(CFG_FAR_CM, {PAD_W'($urandom), far});
    write_reg(CFG_BUZZ_TICKS, buzz);
    cfg_valid <= 1'b0;
  endtask

  // Drive pins that follow the ranger's phase, with some pure noise mixed in
  task automatic run_ticks(input int n);
    logic m;
    logic e;
    repeat (n) begin
      m = 1'($urandom);
      e = 1'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        case (rg_phase)
          PH_IDLE:  m = ($urandom_range(0, 2) == 0);
          PH_WAIT:  e = ($urandom_range(0, 2) == 0);
          PH_COUNT: e = ($urandom_range(0, echo_mean) != 0);
          default: ;
        endcase
      end
      push_tick(m, e, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [TIMER_W-1:0] trig;
    logic [SCALE_W-1:0] scale;
    logic [DIST_W-1:0]  near;
    logic [DIST_W-1:0]  far;
    logic [TIMER_W-1:0] buzz;
    rg_phase = PH_IDLE;
    rg_timer = '0;
    rg_count = '0;
    rg_lamp  = LAMP_OFF;
    rg_dist  = '0;
    live_cfg = '{RST_TRIGGER_TICKS, RST_CM_PER_TICK, RST_NEAR_CM, RST_FAR_CM,
                 RST_BUZZ_TICKS};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    configure(20'd2, 16'hFFFF, 16'd3, 16'd4, 20'd2);
    for (int r = 0; r < DIRECTED_ROWS; r++)
      push_tick(DIRECTED[r].motion, DIRECTED[r].echo, DIRECTED[r].typed, DIRECTED[r].want);

    // Random phases, each with fresh registers and idling mode
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES / 2) begin
        // Longest trigger loaded, but only quiet ticks so no pulse starts
        configure(20'hFFFFF, 16'($urandom), 16'hFFFF, 16'hFFFF, 20'd0);
        repeat (20) push_tick(1'b0, 1'($urandom), 1'b0, '0);
      end
      case ($urandom_range(0, 7))
        0:       trig = '0;
        1:       trig = 20'd1;
        2:       trig = TIMER_W'($urandom_range(50, 200));
        default: trig = TIMER_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       scale = '0;
        1:       scale = 16'hFFFF;
        default: scale = 16'($urandom);
      endcase
      near = ($urandom_range(0, 9) == 0) ? 16'hFFFF : DIST_W'($urandom_range(0, 30));
      far  = ($urandom_range(0, 9) == 0) ? 16'd0 : DIST_W'($urandom_range(0, 30));
      case ($urandom_range(0, 5))
        0:       buzz = '0;
        1:       buzz = 20'd1;
        default: buzz = TIMER_W'($urandom_range(2, 15));
      endcase
      configure(trig, scale, near, far, buzz);
      echo_mean  = $urandom_range(2, 40);
      in_idle_on = ($urandom_range(0, 3) != 0);
      stall_on   = ($urandom_range(0, 3) != 0);
      run_ticks(PHASE_TICKS);
    end

    // Long echo at full scale; idling stops from here on
    in_idle_on = 1'b0;
    stall_on   = 1'b0;
    configure(20'd1, 16'hFFFF, 16'd0, 16'hFFFF, 20'd0);
    push_tick(1'b1, 1'b0, 1'b0, '0);
    push_tick(1'b0, 1'b0, 1'b0, '0);
    repeat (LONG_ECHO) push_tick(1'b0, 1'b1, 1'b0, '0);
    repeat (2) push_tick(1'b0, 1'b0, 1'b0, '0);

    // Zero trigger, crossed thresholds, longest buzz hold to the end
    configure(20'd0, 16'($urandom), 16'hFFFF, 16'd0, 20'hFFFFF);
    echo_mean = 4;
    run_ticks(60);
    settle();

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Throttle the result side in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Score each result beat against the oldest logged one
  always @(posedge clk) begin : score
    ranger_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing due", beat_index));
      end else begin
        want = due_beats.pop_front();
        check_field("trigger", want.trigger, out_trigger);
        check_field("led_red", want.led_red, out_led_red);
        check_field("led_yellow", want.led_yellow, out_led_yellow);
        check_field("led_green", want.led_green, out_led_green);
        check_field("buzzer", want.buzzer, out_buzzer);
        check_field("distance_cm", want.distance_cm, out_distance_cm);
        check_field("measure_done", want.measure_done, out_measure_done);
        check_field("busy_res", want.busy, out_busy_res);
      end
      beat_index++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

@@ ultrasonic_parking_ranger.f @@
+incdir+hdl
hdl/upr_pkg.sv
hdl/upr_cfg_regs.sv
hdl/upr_in_reg.sv
hdl/upr_core.sv
hdl/ultrasonic_parking_ranger.sv
hdl/upr_checker.sv
tb/tb.sv
